// ----- sv/x86ild_pkg.sv -----
`timescale 1ns / 1ps

package x86ild_pkg;

  // A run of this many prefixes in a row is reported as an invalid decode.
  localparam logic [4:0] MAX_LENGTH = 5'd15;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MODRM_MAP_0 = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MODRM_MAP_1 = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_MODRM_MAP_2 = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_MODRM_MAP_3 = 8'd3;

  // Reset value of the ModR/M map: opcodes 0x00 and 0x88 take a ModR/M byte.
  localparam logic [CfgDataW-1:0] MAP_0_RESET = 64'h0000_0000_0000_0001;
  localparam logic [CfgDataW-1:0] MAP_1_RESET = 64'h0000_0000_0000_0000;
  localparam logic [CfgDataW-1:0] MAP_2_RESET = 64'h0000_0000_0000_0100;
  localparam logic [CfgDataW-1:0] MAP_3_RESET = 64'h0000_0000_0000_0000;

  // Segment-override prefix bytes.
  localparam logic [7:0] PFX_ES = 8'h26;
  localparam logic [7:0] PFX_CS = 8'h2E;
  localparam logic [7:0] PFX_SS = 8'h36;
  localparam logic [7:0] PFX_DS = 8'h3E;

  // Segment override codes as reported on the result channel.
  localparam logic [2:0] SEG_NONE = 3'd0;
  localparam logic [2:0] SEG_ES   = 3'd1;
  localparam logic [2:0] SEG_CS   = 3'd2;
  localparam logic [2:0] SEG_SS   = 3'd3;
  localparam logic [2:0] SEG_DS   = 3'd4;

  // ModR/M mod field codes and the rm code that selects a direct address.
  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP16 = 2'd2;
  localparam logic [2:0] RM_DIRECT  = 3'd6;

  typedef struct packed {
    logic              decode_ok;
    logic [4:0]        instr_length;
    logic [2:0]        seg_override;
    logic [7:0]        opcode_byte;
    logic              modrm_present;
    logic [1:0]        mode_bits;
    logic [2:0]        reg_bits;
    logic [2:0]        rm_bits;
    logic signed [15:0] displacement;
  } result_t;

  function automatic logic [2:0] seg_code(input logic [7:0] b);
    logic [2:0] s;
    unique case (b)
      PFX_ES:  s = SEG_ES;
      PFX_CS:  s = SEG_CS;
      PFX_SS:  s = SEG_SS;
      PFX_DS:  s = SEG_DS;
      default: s = SEG_NONE;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/x86_16_instruction_length_decoder.sv -----
`timescale 1ns / 1ps

// 16-bit x86 instruction length decoder.
// The input channel (in_valid/in_ready/in_instr_byte) takes the instruction
// stream one byte per transaction, in fetch order. Segment-override prefixes
// are collected (the last one wins), then the opcode, a ModR/M byte when the
// opcode's bit in the 256-bit ModR/M map is set, and a 0, 1 or 2 byte
// displacement. The last byte of an instruction produces one transaction on
// the result channel (out_valid/out_ready and the out_ fields); a run of
// MAX_LENGTH prefixes produces a result with out_decode_ok low.
// Throughput is one byte per cycle: each byte is handled by a small phase
// update between the decoder state registers and the result register, and a
// result shows up on the outputs the cycle after its last byte is accepted.
// in_ready stays high while the result register is empty or being drained in
// the same cycle, so a stalled receiver holds back input only once a result
// is waiting. The map is to be written through cfg_we/cfg_index/cfg_wdata only
// while the block is idle, which it does not enforce; indexes beyond the four
// map words are ignored. Synchronous reset clears the decoder state and the
// result valid flag and loads the default map (opcodes 0x00, 0x88 take ModR/M).

module x86_16_instruction_length_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [x86ild_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [x86ild_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_instr_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_decode_ok,
  output logic [4:0]                      out_instr_length,
  output logic [2:0]                      out_seg_override,
  output logic [7:0]                      out_opcode_byte,
  output logic                            out_modrm_present,
  output logic [1:0]                      out_mode_bits,
  output logic [2:0]                      out_reg_bits,
  output logic [2:0]                      out_rm_bits,
  output logic signed [15:0]              out_displacement
);
  import x86ild_pkg::*;

  // Where the decoder is inside the current instruction.
  typedef enum logic [2:0] {
    PH_OPC   = 3'd0,  // prefix or opcode byte expected
    PH_MODRM = 3'd1,
    PH_D8    = 3'd2,
    PH_D16L  = 3'd3,
    PH_D16H  = 3'd4
  } phase_t;

  logic [CfgDataW-1:0] map_r [4];

  phase_t     phase_r, phase_nxt;
  logic [4:0] byte_cnt_r, byte_cnt_nxt;
  logic [2:0] held_ovr_r, held_ovr_nxt;
  logic [7:0] held_opc_r, held_opc_nxt;
  logic [7:0] held_modrm_r, held_modrm_nxt;
  logic [7:0] disp_lo_r, disp_lo_nxt;

  logic    out_valid_r;
  result_t res_r, res_nxt;
  logic    emit;

  logic       accept;
  phase_t     cur_phase;
  logic [4:0] cur_cnt;
  logic [2:0] cur_ovr;
  logic [4:0] cnt_inc;
  logic [2:0] seg;
  logic       takes_modrm;
  logic [1:0] b_mod;
  logic [2:0] b_rm;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // A phase code outside the enum cannot arise; if one did, the byte is
    // handled as the first byte of a fresh instruction.
    if (phase_r > PH_D16H) begin
      cur_phase = PH_OPC;
      cur_cnt   = 5'd0;
      cur_ovr   = SEG_NONE;
    end else begin
      cur_phase = phase_r;
      cur_cnt   = byte_cnt_r;
      cur_ovr   = held_ovr_r;
    end

    cnt_inc     = cur_cnt + 5'd1;
    seg         = seg_code(in_instr_byte);
    takes_modrm = map_r[in_instr_byte[7:6]][in_instr_byte[5:0]];
    b_mod       = in_instr_byte[7:6];
    b_rm        = in_instr_byte[2:0];

    phase_nxt      = cur_phase;
    byte_cnt_nxt   = cnt_inc;
    held_ovr_nxt   = cur_ovr;
    held_opc_nxt   = held_opc_r;
    held_modrm_nxt = held_modrm_r;
    disp_lo_nxt    = disp_lo_r;
    emit           = 1'b0;

    res_nxt               = '0;
    res_nxt.decode_ok     = 1'b1;
    res_nxt.instr_length  = cnt_inc;
    res_nxt.seg_override  = cur_ovr;
    res_nxt.opcode_byte   = held_opc_r;
    res_nxt.modrm_present = 1'b1;
    res_nxt.mode_bits     = held_modrm_r[7:6];
    res_nxt.reg_bits      = held_modrm_r[5:3];
    res_nxt.rm_bits       = held_modrm_r[2:0];

    unique case (cur_phase)
      PH_OPC: begin
        if (seg != SEG_NONE) begin
          held_ovr_nxt = seg;
          if (cnt_inc >= MAX_LENGTH) begin
            emit                 = 1'b1;
            res_nxt              = '0;
            res_nxt.instr_length = cnt_inc;
            res_nxt.seg_override = seg;
          end
        end else begin
          held_opc_nxt = in_instr_byte;
          if (takes_modrm) begin
            phase_nxt = PH_MODRM;
          end else begin
            emit                  = 1'b1;
            res_nxt.opcode_byte   = in_instr_byte;
            res_nxt.modrm_present = 1'b0;
            res_nxt.mode_bits     = 2'd0;
            res_nxt.reg_bits      = 3'd0;
            res_nxt.rm_bits       = 3'd0;
          end
        end
      end
      PH_MODRM: begin
        held_modrm_nxt = in_instr_byte;
        if (b_mod == MOD_DISP8) begin
          phase_nxt = PH_D8;
        end else if (b_mod == MOD_DISP16 || (b_mod == MOD_NODISP && b_rm == RM_DIRECT)) begin
          phase_nxt = PH_D16L;
        end else begin
          emit              = 1'b1;
          res_nxt.mode_bits = in_instr_byte[7:6];
          res_nxt.reg_bits  = in_instr_byte[5:3];
          res_nxt.rm_bits   = in_instr_byte[2:0];
        end
      end
      PH_D8: begin
        emit                 = 1'b1;
        res_nxt.displacement = {{8{in_instr_byte[7]}}, in_instr_byte};
      end
      PH_D16L: begin
        disp_lo_nxt = in_instr_byte;
        phase_nxt   = PH_D16H;
      end
      PH_D16H: begin
        emit                 = 1'b1;
        res_nxt.displacement = {in_instr_byte, disp_lo_r};
      end
      default: begin
        phase_nxt = PH_OPC;
      end
    endcase

    // A finished instruction leaves the decoder in its reset state.
    if (emit) begin
      phase_nxt      = PH_OPC;
      byte_cnt_nxt   = 5'd0;
      held_ovr_nxt   = SEG_NONE;
      held_opc_nxt   = 8'd0;
      held_modrm_nxt = 8'd0;
      disp_lo_nxt    = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r[0]     <= MAP_0_RESET;
      map_r[1]     <= MAP_1_RESET;
      map_r[2]     <= MAP_2_RESET;
      map_r[3]     <= MAP_3_RESET;
      phase_r      <= PH_OPC;
      byte_cnt_r   <= 5'd0;
      held_ovr_r   <= SEG_NONE;
      held_opc_r   <= 8'd0;
      held_modrm_r <= 8'd0;
      disp_lo_r    <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODRM_MAP_0: map_r[0] <= cfg_wdata;
          CFG_MODRM_MAP_1: map_r[1] <= cfg_wdata;
          CFG_MODRM_MAP_2: map_r[2] <= cfg_wdata;
          CFG_MODRM_MAP_3: map_r[3] <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        phase_r      <= phase_nxt;
        byte_cnt_r   <= byte_cnt_nxt;
        held_ovr_r   <= held_ovr_nxt;
        held_opc_r   <= held_opc_nxt;
        held_modrm_r <= held_modrm_nxt;
        disp_lo_r    <= disp_lo_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The result register holds its payload while a transaction waits.
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_decode_ok     = res_r.decode_ok;
  assign out_instr_length  = res_r.instr_length;
  assign out_seg_override  = res_r.seg_override;
  assign out_opcode_byte   = res_r.opcode_byte;
  assign out_modrm_present = res_r.modrm_present;
  assign out_mode_bits     = res_r.mode_bits;
  assign out_reg_bits      = res_r.reg_bits;
  assign out_rm_bits       = res_r.rm_bits;
  assign out_displacement  = res_r.displacement;

  // An overflowed prefix run always reports the full length and no opcode.
  a_overflow_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.decode_ok |->
      res_r.instr_length == MAX_LENGTH && res_r.opcode_byte == 8'd0 &&
      !res_r.modrm_present)
    else $error("invalid decode with unexpected length or opcode");

  // Without a ModR/M byte there are no ModR/M fields and no displacement.
  a_no_modrm_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.modrm_present |->
      res_r.mode_bits == 2'd0 && res_r.reg_bits == 3'd0 && res_r.rm_bits == 3'd0 &&
      res_r.displacement == 16'sd0)
    else $error("ModR/M fields set on a result without ModR/M");

  // A prefix run never reaches the overflow length while still collecting.
  a_prefix_bound : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_OPC |-> byte_cnt_r < MAX_LENGTH)
    else $error("prefix count passed the overflow length");

  // The low displacement byte is always followed by the high byte phase.
  a_disp16_order : assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_D16L |=> phase_r == PH_D16H && !$past(emit))
    else $error("16-bit displacement sequence broken");

endmodule
